// ----- design/ofifo_pkg.sv -----
// Package for the overwriting ring FIFO: action codes, field widths and the
// command and status bundles that join the controller and the datapath.
// Depends on nothing; the top level, ofifo_ctrl and ofifo_dp use scoped names.
`default_nettype none

package ofifo_pkg;

  // Widths of the item fields.
  localparam int ACT_W  = 2;
  localparam int WORD_W = 16;
  localparam int CAPF_W = 7;

  // Action codes carried on the input side-band.
  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESIZE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;        // write the incoming word and update the pointers
    logic pop_done;    // read data is back: retire the oldest word
    logic underflow;   // pop asked of an empty buffer
    logic rsz_start;   // latch the resize plan (keep, skip, new capacity)
    logic copy_rd;     // issue one copy read of the resize walk
    logic rsz_commit;  // switch to the freshly written bank and capacity
    logic load_out;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;       // no live words
    logic rsz_needed;  // requested capacity is nonzero and, once saturated, differs from the current one
    logic keep_zero;   // a resize would keep no words
    logic copy_last;   // this copy read is the final one
  } sts_t;

endpackage

`default_nettype wire

// ----- design/overwriting_ring_fifo.sv -----
// Top level of the overwriting ring FIFO: stream ports, controller and
// datapath. Depends on ofifo_pkg, ofifo_ctrl and ofifo_dp.
//
//   Channel  Direction  Beat contents
//   in_      slave      tuser: action; tdata: data_word, new_capacity
//   out_     master     tdata: popped_word, fill_count, current_capacity,
//                              underflow, dropped_oldest
//
// Push, query, a pop of an empty buffer and a resize that changes nothing
// load the result register as soon as they are taken. A pop first waits in
// a read state for the registered read of the word bank. A resize that keeps
// K words walks them one per cycle through the bank's single read port into
// the other bank, then commits in a drain state; input is held off meanwhile.
// Reset is synchronous and active low; it empties the buffer and sets the
// capacity to MAX_CAPACITY. The banks themselves are not cleared.
// A result waits in an output register; the next beat is taken in the cycle
// that result leaves, so a stalled output stalls the input once it is full.
`default_nettype none

module overwriting_ring_fifo #(
  parameter int MAX_CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  input  wire logic [23:0] in_tdata,   // [15:0] data_word, [22:16] new_capacity,
                                       // [23] zero padding
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [15:0] popped_word, [22:16] fill_count,
                                       // [29:23] current_capacity, [30] underflow,
                                       // [31] dropped_oldest
);

  ofifo_pkg::cmd_t cmd;
  ofifo_pkg::sts_t sts;

  logic signed [ofifo_pkg::WORD_W-1:0] popped_word;
  logic        [ofifo_pkg::CAPF_W-1:0] fill_count;
  logic        [ofifo_pkg::CAPF_W-1:0] current_capacity;
  logic                                underflow;
  logic                                dropped_oldest;
  logic                                in_fire;

  assign in_fire = in_tvalid && in_tready;

  ofifo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  ofifo_dp #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_data_word         (in_tdata[15:0]),
    .in_new_capacity      (in_tdata[22:16]),
    .sts                  (sts),
    .out_popped_word      (popped_word),
    .out_fill_count       (fill_count),
    .out_current_capacity (current_capacity),
    .out_underflow        (underflow),
    .out_dropped_oldest   (dropped_oldest)
  );

  assign out_tdata = {dropped_oldest, underflow, current_capacity, fill_count, popped_word};

  // A pop of a non-empty buffer leaves the output idle during the bank read, then delivers its result.
  a_pop_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser == ofifo_pkg::ACT_POP) && !sts.empty
      |=> !out_tvalid ##1 out_tvalid)
    else $error("pop result not delivered on the second cycle");

  // Push and query deliver at once and never report underflow.
  a_push_query : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ((in_tuser == ofifo_pkg::ACT_PUSH) || (in_tuser == ofifo_pkg::ACT_QUERY))
      |=> out_tvalid && !out_tdata[30])
    else $error("push or query result missing or flagged as underflow");

  // A resize that changes the capacity holds off the input, and sends no result, while it runs.
  a_resize_stall : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser == ofifo_pkg::ACT_RESIZE) && sts.rsz_needed
      |=> !in_tready && !out_tvalid)
    else $error("input taken during a resize copy");

endmodule

`default_nettype wire

// ----- design/ofifo_ram.sv -----
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. No dependencies.
`default_nettype none

module ofifo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- design/ofifo_ctrl.sv -----
// Controller of the overwriting ring FIFO: the item sequencer and the
// handshakes of both channels. Depends on ofifo_pkg.
`default_nettype none

module ofifo_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic [ofifo_pkg::ACT_W-1:0]     in_action,
  input  wire logic                            out_tready,
  input  wire ofifo_pkg::sts_t                 sts,
  output logic                                 in_tready,
  output logic                                 out_tvalid,
  output ofifo_pkg::cmd_t                      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_POP_RD = 2'd1;
  localparam logic [1:0] ST_COPY   = 2'd2;
  localparam logic [1:0] ST_DRAIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    // A new beat is taken when idle and the result register is free or
    // being emptied in this very cycle.
    in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
    in_fire   = in_tvalid && in_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ofifo_pkg::ACT_PUSH: begin
              cmd.push     = 1'b1;
              cmd.load_out = 1'b1;
            end
            ofifo_pkg::ACT_POP: begin
              if (sts.empty) begin
                cmd.underflow = 1'b1;
                cmd.load_out  = 1'b1;
              end else begin
                state_nxt = ST_POP_RD;
              end
            end
            ofifo_pkg::ACT_RESIZE: begin
              if (sts.rsz_needed) begin
                cmd.rsz_start = 1'b1;
                state_nxt     = sts.keep_zero ? ST_DRAIN : ST_COPY;
              end else begin
                cmd.load_out = 1'b1;
              end
            end
            default: begin
              cmd.load_out = 1'b1;
            end
          endcase
        end
      end
      ST_POP_RD: begin
        cmd.pop_done = 1'b1;
        cmd.load_out = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        if (sts.copy_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.rsz_commit = 1'b1;
        cmd.load_out   = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- design/ofifo_dp.sv -----
// Datapath of the overwriting ring FIFO: pointers, count, capacity, the two
// word banks, the resize copy walk and the result register.
// Depends on ofifo_pkg and ofifo_ram.
`default_nettype none

module ofifo_dp #(
  parameter int MAX_CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ofifo_pkg::cmd_t                     cmd,
  input  wire logic signed [ofifo_pkg::WORD_W-1:0] in_data_word,
  input  wire logic        [ofifo_pkg::CAPF_W-1:0] in_new_capacity,
  output ofifo_pkg::sts_t                          sts,
  output logic signed      [ofifo_pkg::WORD_W-1:0] out_popped_word,
  output logic             [ofifo_pkg::CAPF_W-1:0] out_fill_count,
  output logic             [ofifo_pkg::CAPF_W-1:0] out_current_capacity,
  output logic                                     out_underflow,
  output logic                                     out_dropped_oldest
);

  localparam int AW   = $clog2(MAX_CAPACITY);
  localparam int CW   = $clog2(MAX_CAPACITY + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > ofifo_pkg::CAPF_W) ? CW : ofifo_pkg::CAPF_W;

  // Index of the word at a given offset from the oldest. Base and offset
  // never reach twice the capacity, so one subtraction wraps it.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off,
                                            input logic [CW-1:0] cap);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(cap)) begin
      sum = sum - SW'(cap);
    end
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic          bank_r, bank_nxt;
  logic          cp_wr_vld_r, cp_wr_vld_nxt;
  logic [AW-1:0] cp_wr_addr_r, cp_wr_addr_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] src_off_r, src_off_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [CW-1:0] rsz_cap_r, rsz_cap_nxt;

  logic signed [ofifo_pkg::WORD_W-1:0] popped_r;
  logic        [ofifo_pkg::CAPF_W-1:0] fill_r, capo_r;
  logic                                under_r, dropped_r;

  logic                        full;
  logic [CMPW-1:0]             req_ext, max_ext;
  logic [CW-1:0]               req_sat, keep_now;
  logic [AW-1:0]               slot_fill, slot_next, copy_src, rd_addr, wr_addr;
  logic [ofifo_pkg::WORD_W-1:0] rd_data0, rd_data1, rd_word, wr_data;
  logic                        we0, we1;

  always_comb begin
    full     = (count_r >= cap_r);
    req_ext  = CMPW'(in_new_capacity);
    max_ext  = CMPW'(MAX_CAPACITY);
    req_sat  = (req_ext > max_ext) ? CW'(max_ext) : CW'(req_ext);
    keep_now = (count_r < req_sat) ? count_r : req_sat;

    sts.empty      = (count_r == '0);
    sts.rsz_needed = (in_new_capacity != '0) && (req_sat != cap_r);
    sts.keep_zero  = (keep_now == '0);
    sts.copy_last  = (k_r == keep_r - CW'(1));

    slot_fill = slot_of(oldest_r, count_r, cap_r);
    slot_next = slot_of(oldest_r, CW'(1), cap_r);
    copy_src  = slot_of(oldest_r, src_off_r, cap_r);
    rd_addr   = cmd.copy_rd ? copy_src : oldest_r;
    rd_word   = bank_r ? rd_data1 : rd_data0;

    // Pushes go to the live bank; copy writes go to the other one.
    wr_addr = cmd.push ? (full ? oldest_r : slot_fill) : cp_wr_addr_r;
    wr_data = cmd.push ? in_data_word : rd_word;
    we0     = (cmd.push && !bank_r) || (cp_wr_vld_r && bank_r);
    we1     = (cmd.push && bank_r) || (cp_wr_vld_r && !bank_r);

    oldest_nxt     = oldest_r;
    count_nxt      = count_r;
    cap_nxt        = cap_r;
    bank_nxt       = bank_r;
    k_nxt          = k_r;
    src_off_nxt    = src_off_r;
    keep_nxt       = keep_r;
    rsz_cap_nxt    = rsz_cap_r;
    cp_wr_vld_nxt  = 1'b0;
    cp_wr_addr_nxt = cp_wr_addr_r;

    if (cmd.push) begin
      if (full) begin
        oldest_nxt = slot_next;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.pop_done) begin
      oldest_nxt = slot_next;
      count_nxt  = count_r - CW'(1);
    end
    if (cmd.rsz_start) begin
      keep_nxt    = keep_now;
      src_off_nxt = count_r - keep_now;
      k_nxt       = '0;
      rsz_cap_nxt = req_sat;
    end
    if (cmd.copy_rd) begin
      k_nxt          = k_r + CW'(1);
      src_off_nxt    = src_off_r + CW'(1);
      cp_wr_vld_nxt  = 1'b1;
      cp_wr_addr_nxt = k_r[AW-1:0];
    end
    if (cmd.rsz_commit) begin
      oldest_nxt = '0;
      count_nxt  = keep_r;
      cap_nxt    = rsz_cap_r;
      bank_nxt   = !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      count_r     <= '0;
      cap_r       <= CW'(MAX_CAPACITY);
      bank_r      <= 1'b0;
      cp_wr_vld_r <= 1'b0;
    end else begin
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      bank_r      <= bank_nxt;
      cp_wr_vld_r <= cp_wr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    src_off_r    <= src_off_nxt;
    keep_r       <= keep_nxt;
    rsz_cap_r    <= rsz_cap_nxt;
    cp_wr_addr_r <= cp_wr_addr_nxt;
    if (cmd.load_out) begin
      popped_r  <= cmd.pop_done ? signed'(rd_word) : '0;
      fill_r    <= ofifo_pkg::CAPF_W'(count_nxt);
      capo_r    <= ofifo_pkg::CAPF_W'(cap_nxt);
      under_r   <= cmd.underflow;
      dropped_r <= cmd.push && full;
    end
  end

  ofifo_ram #(
    .WIDTH (ofifo_pkg::WORD_W),
    .DEPTH (MAX_CAPACITY)
  ) u_bank0 (
    .clk     (clk),
    .wr_en   (we0),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data0)
  );

  ofifo_ram #(
    .WIDTH (ofifo_pkg::WORD_W),
    .DEPTH (MAX_CAPACITY)
  ) u_bank1 (
    .clk     (clk),
    .wr_en   (we1),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data1)
  );

  assign out_popped_word      = popped_r;
  assign out_fill_count       = fill_r;
  assign out_current_capacity = capo_r;
  assign out_underflow        = under_r;
  assign out_dropped_oldest   = dropped_r;

endmodule

`default_nettype wire

// ----- dv/tb_overwriting_ring_fifo.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the overwriting ring FIFO, driven through its
// stream ports. Depends on ofifo_pkg and the overwriting_ring_fifo design.

module tb_overwriting_ring_fifo;

  import ofifo_pkg::*;

  localparam int MAX_CAP         = 64;
  // Cycles without any accepted beat on either side before the run is
  // declared hung. The slowest legal gap is a full-depth resize under a
  // heavily stalled receiver, or the deliberate long receiver hold-off.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  // Quiet time after the last result: a little more than the longest resize.
  localparam int TAIL_CYCLES     = MAX_CAP + 16;

  // One input beat, split into its fields.
  typedef struct {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] word;
    logic [CAPF_W-1:0]        req_cap;
  } fifo_cmd_t;

  // One result beat, split into its fields.
  typedef struct {
    logic signed [WORD_W-1:0] popped;
    logic [CAPF_W-1:0]        fill;
    logic [CAPF_W-1:0]        cap;
    logic                     underflow;
    logic                     dropped;
  } fifo_status_t;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;   // [1:0] action
  logic [23:0] in_tdata   = '0;   // [15:0] data_word, [22:16] new_capacity, [23] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [15:0] popped_word, [22:16] fill_count,
                                  // [29:23] current_capacity, [30] underflow,
                                  // [31] dropped_oldest

  // Stall rates in percent, changed by the test tasks between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Long receiver hold-off: the test bumps the request count and the
  // receiver process, which alone owns the countdown, notices the change.
  int unsigned hold_req_count = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  // Shadow copy of the buffer, advanced once per accepted input beat.
  logic signed [WORD_W-1:0] shadow_words [MAX_CAP];
  int unsigned shadow_head = 0;
  int unsigned shadow_fill = 0;
  int unsigned shadow_cap  = MAX_CAP;

  // Results still owed by the block, oldest first.
  fifo_status_t owed_status_q[$];

  overwriting_ring_fifo #(.MAX_CAPACITY(MAX_CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Works out the result of one command and moves the shadow buffer on.
  // A full push overwrites the oldest word and moves the head past it; a
  // resize keeps only the newest words that fit and re-bases them at slot 0.
  function automatic fifo_status_t apply_fifo_cmd(fifo_cmd_t cmd);
    fifo_status_t st;
    logic signed [WORD_W-1:0] kept [MAX_CAP];
    int unsigned req;
    int unsigned keep;
    int unsigned skip;
    st.popped    = '0;
    st.underflow = 1'b0;
    st.dropped   = 1'b0;
    case (cmd.action)
      ACT_PUSH: begin
        if (shadow_fill >= shadow_cap) begin
          shadow_words[shadow_head] = cmd.word;
          shadow_head = (shadow_head + 1) % shadow_cap;
          st.dropped = 1'b1;
        end else begin
          shadow_words[(shadow_head + shadow_fill) % shadow_cap] = cmd.word;
          shadow_fill++;
        end
      end
      ACT_POP: begin
        if (shadow_fill == 0) begin
          st.underflow = 1'b1;
        end else begin
          st.popped = shadow_words[shadow_head];
          shadow_head = (shadow_head + 1) % shadow_cap;
          shadow_fill--;
        end
      end
      ACT_RESIZE: begin
        req = cmd.req_cap;
        if (req > MAX_CAP) req = MAX_CAP;
        // A zero request and a request for the capacity already in use
        // both leave everything as it is.
        if (req != 0 && req != shadow_cap) begin
          keep = (shadow_fill < req) ? shadow_fill : req;
          skip = shadow_fill - keep;
          for (int k = 0; k < keep; k++)
            kept[k] = shadow_words[(shadow_head + skip + k) % shadow_cap];
          for (int k = 0; k < keep; k++)
            shadow_words[k] = kept[k];
          shadow_head = 0;
          shadow_fill = keep;
          shadow_cap  = req;
        end
      end
      default: begin
      end
    endcase
    st.fill = shadow_fill[CAPF_W-1:0];
    st.cap  = shadow_cap[CAPF_W-1:0];
    return st;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Offers one beat and returns once it has been taken. tvalid is left high,
  // so back-to-back beats never lower and raise it within one time step.
  task automatic send_beat(input logic [ACT_W-1:0] action,
                           input logic [WORD_W-1:0] word,
                           input logic [CAPF_W-1:0] req_cap);
    fifo_cmd_t cmd;
    cmd.action  = action;
    cmd.word    = word;
    cmd.req_cap = req_cap;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd.action;
    in_tdata  <= {1'b0, cmd.req_cap, cmd.word};
    // Signals read straight after the edge still hold their pre-edge values.
    do @(posedge clk); while (!in_tready);
    owed_status_q.push_back(apply_fifo_cmd(cmd));
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    while (owed_status_q.size() != 0) @(posedge clk);
  endtask

  // Mostly small capacities keep resizes short and make full buffers common;
  // a few requests are zero or beyond the maximum, which must saturate.
  function automatic logic [CAPF_W-1:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return CAPF_W'($urandom_range(12, 1));
    if (r < 88) return CAPF_W'($urandom_range(MAX_CAP, 13));
    if (r < 94) return '0;
    return CAPF_W'($urandom_range(127, MAX_CAP + 1));
  endfunction

  task automatic send_random_beat(input int unsigned push_pct, input int unsigned pop_pct);
    int unsigned r;
    logic [ACT_W-1:0] action;
    r = $urandom_range(99);
    if (r < push_pct)                action = ACT_PUSH;
    else if (r < push_pct + pop_pct) action = ACT_POP;
    else if (r < push_pct + pop_pct + 8) action = ACT_RESIZE;
    else                             action = ACT_QUERY;
    send_beat(action, WORD_W'($urandom), pick_capacity());
  endtask

  // Extremes of the word, every action, and the special cases: a pop of an
  // empty buffer, a resize to the capacity in use, a resize to zero, a
  // request above the maximum, shrinking a partly full buffer, and pushes
  // into a full buffer at capacity one and two.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(ACT_QUERY,  16'h0000, 7'd0);
    send_beat(ACT_POP,    16'hFFFF, 7'd127);
    send_beat(ACT_PUSH,   16'h7FFF, 7'd0);
    send_beat(ACT_PUSH,   16'h8000, 7'd127);
    send_beat(ACT_PUSH,   16'h0000, 7'd0);
    send_beat(ACT_PUSH,   16'h0001, 7'd0);
    send_beat(ACT_RESIZE, 16'hFFFF, 7'(MAX_CAP));
    send_beat(ACT_RESIZE, 16'h0000, 7'd0);
    send_beat(ACT_RESIZE, 16'h0000, 7'd2);
    send_beat(ACT_PUSH,   16'hFFFF, 7'd0);
    send_beat(ACT_PUSH,   16'h5555, 7'd0);
    send_beat(ACT_POP,    16'h0000, 7'd0);
    send_beat(ACT_RESIZE, 16'h0000, 7'd127);
    send_beat(ACT_PUSH,   16'hAAAA, 7'd0);
    send_beat(ACT_POP,    16'h0000, 7'd0);
    send_beat(ACT_POP,    16'h0000, 7'd0);
    send_beat(ACT_POP,    16'h0000, 7'd0);
    send_beat(ACT_RESIZE, 16'h0000, 7'd1);
    send_beat(ACT_PUSH,   16'h1234, 7'd0);
    send_beat(ACT_PUSH,   16'hFEDC, 7'd0);
    send_beat(ACT_POP,    16'h0000, 7'd0);
    send_beat(ACT_RESIZE, 16'h0000, 7'(MAX_CAP));
    send_beat(ACT_QUERY,  16'hFFFF, 7'd127);
    send_beat(ACT_POP,    16'h0000, 7'd0);
    stop_sending();
  endtask

  // Random traffic at the given stall rates. The mix alternates between
  // filling and draining stretches so that both full and empty buffers recur.
  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned n_beats);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_beats; i++) begin
      if ((i / 40) % 2 == 0) send_random_beat(55, 25);
      else                   send_random_beat(25, 55);
    end
    stop_sending();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering a full-depth stream of pushes, so the output register fills and
  // the input stalls; the buffer also fills and starts dropping. The sender
  // then pauses until every owed result has arrived before draining it.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(ACT_RESIZE, 16'h0000, 7'(MAX_CAP));
    hold_req_count <= hold_req_count + 1;
    for (int i = 0; i < MAX_CAP + 8; i++)
      send_beat(ACT_PUSH, WORD_W'($urandom), 7'd0);
    send_beat(ACT_QUERY, 16'h0000, 7'd0);
    stop_sending();
    wait_for_results();
    for (int i = 0; i < 12; i++)
      send_beat(ACT_POP, 16'h0000, 7'd0);
    send_beat(ACT_RESIZE, 16'h0000, 7'd5);
    stop_sending();
    wait_for_results();
  endtask

  // Receiver: random stalls, or the long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req_count != hold_seen) begin
      hold_seen  <= hold_req_count;
      hold_left  <= HOLD_OFF_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: each result beat is compared with the oldest owed one.
  always @(posedge clk) begin
    fifo_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_status_q.size() == 0) begin
        report_mismatch("unexpected result beat, owed count", 1, 0);
      end else begin
        want = owed_status_q.pop_front();
        if (out_tdata[15:0] !== want.popped)
          report_mismatch("popped_word", $signed(out_tdata[15:0]), want.popped);
        if (out_tdata[22:16] !== want.fill)
          report_mismatch("fill_count", out_tdata[22:16], want.fill);
        if (out_tdata[29:23] !== want.cap)
          report_mismatch("current_capacity", out_tdata[29:23], want.cap);
        if (out_tdata[30] !== want.underflow)
          report_mismatch("underflow", out_tdata[30], want.underflow);
        if (out_tdata[31] !== want.dropped)
          report_mismatch("dropped_oldest", out_tdata[31], want.dropped);
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_overwriting_ring_fifo NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(0, 0, 340);
    test_random(80, 0, 340);
    test_random(0, 80, 340);
    test_random(36, 36, 340);
    test_backpressure();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_status_q.size() != 0)
      report_mismatch("results left owed at the end", owed_status_q.size(), 0);
    if (error_count == 0) begin
      $display("tb_overwriting_ring_fifo OK");
    end else begin
      $display("tb_overwriting_ring_fifo NOT OK");
    end
    $finish;
  end

endmodule
